/* hdl/tli_pkg.sv */
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types and constants of the table linear interpolator: field widths,
// operation and status codes, and the payload and command structs.
// ----------------------------------------------------------------------------
package tli_pkg;

    localparam int VALUE_WIDTH     = 24;
    localparam int INDEX_WIDTH     = 8;
    localparam int SEG_WIDTH       = 8;
    localparam int STATUS_WIDTH    = 2;
    localparam int CFG_WIDTH       = 9;
    localparam int DEF_TABLE_DEPTH = 256;
    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int RES_QUEUE_DEPTH = 2;
    localparam logic [CFG_WIDTH-1:0] CFG_RESET = CFG_WIDTH'(2);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [STATUS_WIDTH-1:0] ST_INSIDE = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_BELOW  = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_ABOVE  = 2'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_FLAT   = 2'd3;

    typedef struct packed {
        logic                   opcode;
        logic [INDEX_WIDTH-1:0] entry_index;
        logic [VALUE_WIDTH-1:0] entry_momentum;
        logic [VALUE_WIDTH-1:0] entry_range;
        logic [VALUE_WIDTH-1:0] query_momentum;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] range_value;
        logic [SEG_WIDTH-1:0]          segment_index;
        logic [STATUS_WIDTH-1:0]       position_status;
    } t_out_item;

    typedef struct packed {
        logic                   is_query;
        logic [INDEX_WIDTH-1:0] index;
        logic [VALUE_WIDTH-1:0] momentum;
        logic [VALUE_WIDTH-1:0] range_val;
    } t_cmd;

endpackage

/* hdl/tli_ram.sv */
// ----------------------------------------------------------------------------
// tli_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tli_ram #(
    parameter int WIDTH = tli_pkg::VALUE_WIDTH,
    parameter int DEPTH = tli_pkg::DEF_TABLE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/tli_fifo.sv */
// ----------------------------------------------------------------------------
// tli_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module tli_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tli_pkg::CMD_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* hdl/tli_front.sv */
// ----------------------------------------------------------------------------
// tli_front
// Input side: accepts transactions, classifies loads and queries, drops loads
// outside the table and queues commands for the back end.
// ----------------------------------------------------------------------------
module tli_front #(
    parameter int TABLE_DEPTH = tli_pkg::DEF_TABLE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tli_pkg::t_in_item i_item,
    output logic              o_full,
    output logic              o_cmd_valid,
    output tli_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_pop
);

    localparam int CMD_W = $bits(tli_pkg::t_cmd);

    tli_pkg::t_cmd    cmd;
    logic             is_query;
    logic             keep;
    logic             enq;
    logic             q_empty;
    logic [CMD_W-1:0] q_rdata;

    assign is_query = (i_item.opcode == tli_pkg::OP_QUERY);
    assign keep     = is_query || (32'(i_item.entry_index) < 32'(TABLE_DEPTH));
    assign enq      = i_push && keep;

    always_comb begin
        cmd.is_query  = is_query;
        cmd.index     = i_item.entry_index;
        cmd.momentum  = is_query ? i_item.query_momentum : i_item.entry_momentum;
        cmd.range_val = i_item.entry_range;
    end

    tli_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (tli_pkg::CMD_QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (enq),
        .i_data  (cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    assign o_cmd       = tli_pkg::t_cmd'(q_rdata);
    assign o_cmd_valid = !q_empty;

endmodule

/* hdl/tli_back.sv */
// ----------------------------------------------------------------------------
// tli_back
// Execution side: holds the point tables, scans them for a query, reads the
// segment, multiplies, divides one quotient bit a cycle, rounds, saturates and
// queues the result transaction.
// ----------------------------------------------------------------------------
module tli_back #(
    parameter int TABLE_DEPTH = tli_pkg::DEF_TABLE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [tli_pkg::CFG_WIDTH-1:0]   i_entries_in_use,
    input  logic                            i_cmd_valid,
    input  tli_pkg::t_cmd                   i_cmd,
    output logic                            o_cmd_pop,
    output tli_pkg::t_out_item              o_result,
    output logic                            o_empty,
    input  logic                            i_pop
);

    localparam int VW    = tli_pkg::VALUE_WIDTH;
    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int PW    = 2 * VW;
    localparam int SW    = PW + 2;
    localparam int DCW   = $clog2(PW);
    localparam int NW    = (AW + 1 > tli_pkg::CFG_WIDTH) ? AW + 1 : tli_pkg::CFG_WIDTH;
    localparam int RES_W = $bits(tli_pkg::t_out_item);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_SEL  = 4'd2;
    localparam logic [3:0] S_RD1  = 4'd3;
    localparam logic [3:0] S_RD2  = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_RND  = 4'd7;
    localparam logic [3:0] S_SAT  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    localparam logic signed [SW-1:0] RES_HI = $signed({{(SW - VW + 1){1'b0}}, {(VW - 1){1'b1}}});
    localparam logic signed [SW-1:0] RES_LO = $signed({{(SW - VW + 1){1'b1}}, {(VW - 1){1'b0}}});

    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic              r_issue;
    logic              r_cmp_valid;
    logic              r_found;
    logic [AW-1:0]     r_scan_idx;
    logic [AW-1:0]     r_cmp_idx;
    logic [AW-1:0]     r_loc;
    logic [AW-1:0]     r_last;
    logic [AW-1:0]     r_seg;
    logic [VW-1:0]     r_q;
    logic [VW-1:0]     r_x1;
    logic [VW-1:0]     r_y1;
    logic [VW-1:0]     r_adx;
    logic [VW-1:0]     r_ady;
    logic [VW-1:0]     r_adm;
    logic              r_neg;
    logic [1:0]        r_status;
    logic [PW-1:0]     r_quo;
    logic [VW:0]       r_rem;
    logic [DCW-1:0]    r_cnt;
    logic [VW-1:0]     r_res;

    logic [NW-1:0]     cfg_ext;
    logic [NW-1:0]     n_used;
    logic [AW-1:0]     last_calc;
    logic [AW-1:0]     seg_sel;
    logic [1:0]        stat_sel;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [VW-1:0]     mom_rdata;
    logic [VW-1:0]     rng_rdata;
    logic [VW:0]       dx;
    logic [VW:0]       dy;
    logic [VW:0]       dm;
    logic [PW-1:0]     prod;
    logic [VW:0]       rem_sh;
    logic              rem_ge;
    logic              round_up;
    logic signed [SW-1:0] y1_ext;
    logic signed [SW-1:0] quo_ext;
    logic signed [SW-1:0] sum;
    logic [VW-1:0]     sat;
    logic              res_full;
    logic              res_push;
    logic [RES_W-1:0]  res_rdata;
    tli_pkg::t_out_item res_item;

    // clamp the configured count to [2, TABLE_DEPTH]
    always_comb begin
        cfg_ext = NW'(i_entries_in_use);
        if (cfg_ext < NW'(2)) begin
            n_used = NW'(2);
        end else if (cfg_ext > NW'(TABLE_DEPTH)) begin
            n_used = NW'(TABLE_DEPTH);
        end else begin
            n_used = cfg_ext;
        end
        last_calc = AW'(n_used - NW'(1));
    end

    always_comb begin
        if (!r_found) begin
            seg_sel  = '0;
            stat_sel = tli_pkg::ST_BELOW;
        end else if (r_loc == r_last) begin
            seg_sel  = r_last - AW'(1);
            stat_sel = tli_pkg::ST_ABOVE;
        end else begin
            seg_sel  = r_loc;
            stat_sel = tli_pkg::ST_INSIDE;
        end
    end

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign ram_we    = o_cmd_pop && !i_cmd.is_query;
    assign ram_waddr = AW'(i_cmd.index);

    always_comb begin
        case (r_state)
            S_SCAN:  ram_raddr = r_scan_idx;
            S_SEL:   ram_raddr = seg_sel;
            S_RD1:   ram_raddr = r_seg + AW'(1);
            default: ram_raddr = r_seg;
        endcase
    end

    tli_ram #(
        .WIDTH (VW),
        .DEPTH (TABLE_DEPTH)
    ) u_mom_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.momentum),
        .i_raddr (ram_raddr),
        .o_rdata (mom_rdata)
    );

    tli_ram #(
        .WIDTH (VW),
        .DEPTH (TABLE_DEPTH)
    ) u_rng_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.range_val),
        .i_raddr (ram_raddr),
        .o_rdata (rng_rdata)
    );

    assign dx   = {1'b0, mom_rdata} - {1'b0, r_x1};
    assign dy   = {1'b0, rng_rdata} - {1'b0, r_y1};
    assign dm   = {1'b0, r_q} - {1'b0, r_x1};
    assign prod = r_ady * r_adm;

    assign rem_sh   = {r_rem[VW-1:0], r_quo[PW-1]};
    assign rem_ge   = (rem_sh >= {1'b0, r_adx});
    assign round_up = ({r_rem[VW-1:0], 1'b0} >= {1'b0, r_adx});

    assign y1_ext  = $signed({{(SW - VW){1'b0}}, r_y1});
    assign quo_ext = $signed({2'b00, r_quo});
    assign sum     = r_neg ? (y1_ext - quo_ext) : (y1_ext + quo_ext);

    always_comb begin
        if (sum > RES_HI) begin
            sat = RES_HI[VW-1:0];
        end else if (sum < RES_LO) begin
            sat = RES_LO[VW-1:0];
        end else begin
            sat = sum[VW-1:0];
        end
    end

    assign res_push = (r_state == S_OUT) && !res_full;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && i_cmd.is_query) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cmp_valid && (r_cmp_idx == r_last)) begin
                    n_state = S_SEL;
                end
            end
            S_SEL:  n_state = S_RD1;
            S_RD1:  n_state = S_RD2;
            S_RD2:  n_state = S_MUL;
            S_MUL:  n_state = (r_status == tli_pkg::ST_FLAT) ? S_OUT : S_DIV;
            S_DIV: begin
                if (r_cnt == DCW'(PW - 1)) begin
                    n_state = S_RND;
                end
            end
            S_RND:  n_state = S_SAT;
            S_SAT:  n_state = S_OUT;
            S_OUT: begin
                if (!res_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= 1'b0;
            r_cmp_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    r_issue     <= 1'b1;
                    r_cmp_valid <= 1'b0;
                    r_found     <= 1'b0;
                end
                S_SCAN: begin
                    if (r_issue && (r_scan_idx == r_last)) begin
                        r_issue <= 1'b0;
                    end
                    r_cmp_valid <= r_issue;
                    if (r_cmp_valid && (mom_rdata < r_q)) begin
                        r_found <= 1'b1;
                    end
                end
                default: begin
                    r_issue     <= 1'b0;
                    r_cmp_valid <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_scan_idx <= '0;
                r_loc      <= '0;
                r_q        <= i_cmd.momentum;
                r_last     <= last_calc;
            end
            S_SCAN: begin
                if (r_issue && (r_scan_idx != r_last)) begin
                    r_scan_idx <= r_scan_idx + AW'(1);
                end
                r_cmp_idx <= r_scan_idx;
                if (r_cmp_valid && (mom_rdata < r_q)) begin
                    r_loc <= r_cmp_idx;
                end
            end
            S_SEL: begin
                r_seg    <= seg_sel;
                r_status <= stat_sel;
            end
            S_RD1: begin
                r_x1 <= mom_rdata;
                r_y1 <= rng_rdata;
            end
            S_RD2: begin
                r_adx <= dx[VW] ? VW'(-dx) : dx[VW-1:0];
                r_ady <= dy[VW] ? VW'(-dy) : dy[VW-1:0];
                r_adm <= dm[VW] ? VW'(-dm) : dm[VW-1:0];
                r_neg <= dx[VW] ^ dy[VW] ^ dm[VW];
                if (mom_rdata == r_x1) begin
                    r_status <= tli_pkg::ST_FLAT;
                end
            end
            S_MUL: begin
                r_quo <= prod;
                r_rem <= '0;
                r_cnt <= '0;
                r_res <= '0;
            end
            S_DIV: begin
                r_rem <= rem_ge ? (rem_sh - {1'b0, r_adx}) : rem_sh;
                r_quo <= {r_quo[PW-2:0], rem_ge};
                r_cnt <= r_cnt + DCW'(1);
            end
            S_RND: begin
                r_quo <= r_quo + PW'(round_up);
            end
            S_SAT: begin
                r_res <= sat;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res_item.range_value     = $signed(r_res);
        res_item.segment_index   = tli_pkg::SEG_WIDTH'(r_seg);
        res_item.position_status = r_status;
    end

    tli_fifo #(
        .WIDTH (RES_W),
        .DEPTH (tli_pkg::RES_QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_item),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (res_rdata),
        .o_empty (o_empty)
    );

    assign o_result = tli_pkg::t_out_item'(res_rdata);

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_adx != '0))
        else $error("divide started on a zero-width segment");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < {1'b0, r_adx}))
        else $error("partial remainder not below divisor");

    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD1) |-> (r_seg < r_last))
        else $error("segment lower index past last usable segment");

    a_flat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_push && (r_status == tli_pkg::ST_FLAT)) |-> (r_res == '0))
        else $error("zero-width segment result not zero");

endmodule

/* hdl/table_linear_interpolator.sv */
// ----------------------------------------------------------------------------
// table_linear_interpolator
// Momentum to range conversion by piecewise linear interpolation over a table
// of up to TABLE_DEPTH points.
//
// A load transaction writes one (momentum, range) point and is retired by the
// back end in the same cycle that it is taken from the input queue; it gives
// no result. For a query, the table scan reads one momentum entry per cycle
// through the momentum RAM's single read port, and the divider produces one
// quotient bit per cycle. Queries are carried out one at a time; up to two
// commands wait in the input queue and up to two results in the output
// queue, so either side may stall until these queues fill without blocking
// the other. The result is signed Q16.8, saturated; status flags
// extrapolation below the first point, above the last point, and a
// zero-width segment (result 0). entries_in_use is taken as 2 below 2 and as
// TABLE_DEPTH above it. Table entries hold nothing until loaded.
// ----------------------------------------------------------------------------
module table_linear_interpolator #(
    parameter int TABLE_DEPTH = tli_pkg::DEF_TABLE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tli_pkg::CFG_WIDTH-1:0] i_cfg_wdata,
    input  logic                          push,
    input  tli_pkg::t_in_item             i_item,
    output logic                          full,
    output tli_pkg::t_out_item            o_result,
    output logic                          empty,
    input  logic                          pop
);

    logic [tli_pkg::CFG_WIDTH-1:0] r_entries_in_use;
    logic                          cmd_valid;
    logic                          cmd_pop;
    tli_pkg::t_cmd                 cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_in_use <= tli_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_entries_in_use <= i_cfg_wdata;
        end
    end

    tli_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    tli_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_entries_in_use (r_entries_in_use),
        .i_cmd_valid      (cmd_valid),
        .i_cmd            (cmd),
        .o_cmd_pop        (cmd_pop),
        .o_result         (o_result),
        .o_empty          (empty),
        .i_pop            (pop)
    );

endmodule

/* dv/table_linear_interpolator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// table_linear_interpolator_tb
// Self-checking bench for the momentum to range interpolation table. Loads
// tables through the command queue, queries them and compares every result
// field with a local predictor of the search and rounding rules. Runs a
// directed set of corner cases, a long result-side stall that fills the
// block, then random tables and queries across several table sizes.
// ----------------------------------------------------------------------------
module table_linear_interpolator_tb;

    localparam int DRAIN_CYCLES = 400;
    localparam int TARGET_ITEMS = 700;
    localparam logic [tli_pkg::VALUE_WIDTH-1:0] VAL_MAX = '1;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [tli_pkg::CFG_WIDTH-1:0] i_cfg_wdata = '0;
    logic                          push        = 1'b0;
    tli_pkg::t_in_item             i_item      = '0;
    logic                          full;
    tli_pkg::t_out_item            o_result;
    logic                          empty;
    logic                          pop         = 1'b0;

    // predictor state
    logic [tli_pkg::VALUE_WIDTH-1:0] momentum_points [tli_pkg::DEF_TABLE_DEPTH];
    logic [tli_pkg::VALUE_WIDTH-1:0] range_points    [tli_pkg::DEF_TABLE_DEPTH];
    bit                              point_loaded    [tli_pkg::DEF_TABLE_DEPTH] =
                                         '{default: 1'b0};
    logic [tli_pkg::CFG_WIDTH-1:0]   points_in_use   = tli_pkg::CFG_RESET;
    tli_pkg::t_out_item              expected_ranges [$];

    int mismatches     = 0;
    int items_accepted = 0;
    int burst_left     = 0;
    bit no_gaps        = 1'b0;
    int hold_request   = 0;

    table_linear_interpolator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .o_result    (o_result),
        .empty       (empty),
        .pop         (pop)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("FAIL table_linear_interpolator");
        $finish;
    end

    function automatic int clamped_points();
        if (points_in_use < 2) return 2;
        if (points_in_use > tli_pkg::DEF_TABLE_DEPTH) return tli_pkg::DEF_TABLE_DEPTH;
        return int'(points_in_use);
    endfunction

    function automatic tli_pkg::t_out_item interpolate_range(
        input logic [tli_pkg::VALUE_WIDTH-1:0] q
    );
        tli_pkg::t_out_item               r;
        int                               n;
        int                               last_below;
        int                               seg;
        bit                               any_below;
        bit                               neg;
        logic [tli_pkg::STATUS_WIDTH-1:0] status;
        longint                           x1, x2, y1, y2, dy, dm, dx;
        longint                           mag, prod, quo, rem, sum, hi_lim, lo_lim;
        n = clamped_points();
        any_below = 1'b0;
        last_below = 0;
        for (int i = 0; i < n; i++) begin
            if (momentum_points[i] < q) begin
                last_below = i;
                any_below = 1'b1;
            end
        end
        if (!any_below) begin
            seg = 0;
            status = tli_pkg::ST_BELOW;
        end else if (last_below == n - 1) begin
            seg = n - 2;
            status = tli_pkg::ST_ABOVE;
        end else begin
            seg = last_below;
            status = tli_pkg::ST_INSIDE;
        end
        x1 = longint'(momentum_points[seg]);
        x2 = longint'(momentum_points[seg + 1]);
        y1 = longint'(range_points[seg]);
        y2 = longint'(range_points[seg + 1]);
        r.segment_index = tli_pkg::SEG_WIDTH'(seg);
        if (x1 == x2) begin
            r.range_value = '0;
            status = tli_pkg::ST_FLAT;
        end else begin
            dy = y2 - y1;
            dm = longint'(q) - x1;
            dx = x2 - x1;
            neg = ((dy < 0) != (dm < 0)) != (dx < 0);
            mag = (dx < 0) ? -dx : dx;
            prod = ((dy < 0) ? -dy : dy) * ((dm < 0) ? -dm : dm);
            quo = prod / mag;
            rem = prod % mag;
            if (dy == 0 || dm == 0) begin
                quo = 0;
            end else if (rem >= mag - rem) begin
                quo++;
            end
            if (quo > (longint'(1) << 40)) quo = longint'(1) << 40;
            sum = y1 + (neg ? -quo : quo);
            hi_lim = (longint'(1) << (tli_pkg::VALUE_WIDTH - 1)) - 1;
            lo_lim = -hi_lim - 1;
            if (sum > hi_lim) sum = hi_lim;
            if (sum < lo_lim) sum = lo_lim;
            r.range_value = tli_pkg::VALUE_WIDTH'(sum);
        end
        r.position_status = status;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_item(input tli_pkg::t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = no_gaps ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        burst_left--;
        items_accepted++;
        if (it.opcode == tli_pkg::OP_LOAD) begin
            momentum_points[it.entry_index] = it.entry_momentum;
            range_points[it.entry_index]    = it.entry_range;
            point_loaded[it.entry_index]    = 1'b1;
        end else begin
            expected_ranges.insert(expected_ranges.size(),
                                   interpolate_range(it.query_momentum));
        end
    endtask

    task automatic load_point(input int idx, input logic [tli_pkg::VALUE_WIDTH-1:0] x,
                              input logic [tli_pkg::VALUE_WIDTH-1:0] y);
        tli_pkg::t_in_item it;
        it.opcode         = tli_pkg::OP_LOAD;
        it.entry_index    = tli_pkg::INDEX_WIDTH'(idx);
        it.entry_momentum = x;
        it.entry_range    = y;
        it.query_momentum = tli_pkg::VALUE_WIDTH'($urandom);
        send_item(it);
    endtask

    task automatic query_point(input logic [tli_pkg::VALUE_WIDTH-1:0] q);
        tli_pkg::t_in_item it;
        it.opcode         = tli_pkg::OP_QUERY;
        it.entry_index    = tli_pkg::INDEX_WIDTH'($urandom);
        it.entry_momentum = tli_pkg::VALUE_WIDTH'($urandom);
        it.entry_range    = tli_pkg::VALUE_WIDTH'($urandom);
        it.query_momentum = q;
        send_item(it);
    endtask

    // drop push, drain all results, let trailing loads retire
    task automatic wait_idle();
        push <= 1'b0;
        burst_left = 0;
        while (expected_ranges.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_points_in_use(input int value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= tli_pkg::CFG_WIDTH'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        points_in_use = tli_pkg::CFG_WIDTH'(value);
    endtask

    task automatic test_directed_cases();
        write_points_in_use(2);
        load_point(0, 24'h000100, 24'h001000);
        load_point(1, 24'h000200, 24'h002000);
        query_point(24'h000000);
        query_point(24'h000100);
        query_point(24'h000180);
        query_point(24'h000200);
        query_point(24'h000201);
        query_point(VAL_MAX);
        load_point(1, 24'h000200, 24'h000000);
        query_point(VAL_MAX);
        load_point(0, VAL_MAX, VAL_MAX);
        load_point(1, VAL_MAX, VAL_MAX);
        query_point(VAL_MAX);
        query_point(24'h000000);
        load_point(1, 24'h000000, 24'h000000);
        query_point(24'h000001);
        load_point(0, 24'h000000, 24'h000000);
        load_point(1, 24'h000002, 24'h000001);
        load_point(2, 24'h010000, 24'h7FFFFF);
        write_points_in_use(0);
        query_point(24'h000001);
        write_points_in_use(1);
        query_point(24'h800000);
        write_points_in_use(3);
        query_point(24'h000001);
        query_point(24'h008000);
    endtask

    task automatic test_long_stall();
        write_points_in_use(2);
        load_point(0, 24'h001000, 24'h000100);
        load_point(1, 24'h009000, 24'h005000);
        no_gaps = 1'b1;
        hold_request = 1500;
        repeat (12) query_point(tli_pkg::VALUE_WIDTH'($urandom));
        no_gaps = 1'b0;
    endtask

    task automatic run_table_phase(input int cfg_value);
        int                              n;
        int                              mode;
        int                              queries;
        int                              x;
        int                              step_cap;
        bit                              fresh;
        logic [tli_pkg::VALUE_WIDTH-1:0] q;
        logic [tli_pkg::VALUE_WIDTH-1:0] lo;
        logic [tli_pkg::VALUE_WIDTH-1:0] hi;
        write_points_in_use(cfg_value);
        no_gaps = ($urandom_range(0, 3) == 0);
        n = clamped_points();
        fresh = (n <= 64);
        for (int k = 0; k < n; k++) begin
            if (!point_loaded[k]) fresh = 1'b1;
        end
        if (fresh) begin
            mode = $urandom_range(0, 7);
            x = $urandom_range(0, 4095);
            step_cap = $urandom_range(1, (int'(VAL_MAX) - x) / n);
            for (int k = 0; k < n; k++) begin
                if (mode == 0) begin
                    load_point(k, tli_pkg::VALUE_WIDTH'($urandom),
                               tli_pkg::VALUE_WIDTH'($urandom));
                end else begin
                    load_point(k, tli_pkg::VALUE_WIDTH'(x), tli_pkg::VALUE_WIDTH'($urandom));
                    if (mode == 1) begin
                        x += $urandom_range(0, 1);
                    end else if ($urandom_range(0, 15) != 0) begin
                        x += $urandom_range(1, step_cap);
                    end
                end
            end
        end
        queries = $urandom_range(15, 40);
        for (int k = 0; k < queries; k++) begin
            if ($urandom_range(0, 7) == 0) begin
                load_point($urandom_range(0, tli_pkg::DEF_TABLE_DEPTH - 1),
                           tli_pkg::VALUE_WIDTH'($urandom),
                           tli_pkg::VALUE_WIDTH'($urandom));
            end
            lo = momentum_points[0];
            hi = momentum_points[n - 1];
            case ($urandom_range(0, 9))
                0: q = '0;
                1: q = VAL_MAX;
                2, 3, 4: q = tli_pkg::VALUE_WIDTH'(
                                 int'(momentum_points[$urandom_range(0, n - 1)])
                                 + $urandom_range(0, 2) - 1);
                default: q = (lo < hi) ? tli_pkg::VALUE_WIDTH'($urandom_range(lo, hi))
                                       : tli_pkg::VALUE_WIDTH'($urandom);
            endcase
            query_point(q);
        end
    endtask

    task automatic test_random_tables();
        int plan[$] = '{5, 256, 2, 511, 9, 1, 300, 0, 17, 3};
        foreach (plan[i]) run_table_phase(plan[i]);
        while (items_accepted < TARGET_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                run_table_phase($urandom_range(33, 511));
            end else begin
                run_table_phase($urandom_range(2, 32));
            end
        end
    endtask

    // result side: long hold on request, otherwise a stall pattern
    initial begin : result_drain
        logic [31:0] pattern;
        int          pos;
        pattern = '1;
        pos = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_request--;
                pop <= 1'b0;
            end else begin
                if (pos == 0) begin
                    case ($urandom_range(0, 3))
                        0: pattern = '1;
                        1: pattern = $urandom;
                        2: pattern = $urandom | $urandom;
                        default: pattern = $urandom & $urandom;
                    endcase
                end
                pop <= pattern[pos];
                pos = (pos + 1) % 32;
            end
        end
    end

    always @(posedge i_clk) begin : check_result
        tli_pkg::t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (expected_ranges.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction range=%h seg=%0d status=%0d",
                                          o_result.range_value, o_result.segment_index,
                                          o_result.position_status));
            end else begin
                want = expected_ranges.pop_front();
                if (o_result.range_value !== want.range_value ||
                    o_result.segment_index !== want.segment_index ||
                    o_result.position_status !== want.position_status) begin
                    report_mismatch($sformatf(
                        "range %h/%h seg %0d/%0d status %0d/%0d (got/want)",
                        o_result.range_value, want.range_value,
                        o_result.segment_index, want.segment_index,
                        o_result.position_status, want.position_status));
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_long_stall();
        test_random_tables();
        wait_idle();
        if (mismatches == 0) begin
            $display("PASS table_linear_interpolator");
        end else begin
            $display("FAIL table_linear_interpolator");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/tli_pkg.sv
hdl/tli_ram.sv
hdl/tli_fifo.sv
hdl/tli_front.sv
hdl/tli_back.sv
hdl/table_linear_interpolator.sv
dv/table_linear_interpolator_tb.sv
